// ===== hw/rtl/modexp_pkg.sv =====
// Shared types and constants for the modular exponentiation block.
// No dependencies; used by modexp_mul, modular_exponentiation and modexp_chk.
`timescale 1ns / 1ps

package modexp_pkg;

	// width of the base operand and of the multiplier's serial operand
	localparam int BASE_WIDTH = 32;
	// bit counter for one serial multiply
	localparam int CNT_W = $clog2(BASE_WIDTH);
	localparam logic [31:0] MODULUS_RESET = 32'd1000000007;

	// operation codes on the op field
	localparam logic OP_POWER   = 1'b0;
	localparam logic OP_INVERSE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_STEP,
		ST_MUL,
		ST_FINISH
	} state_t;

endpackage

// ===== hw/rtl/modular_exponentiation.sv =====
// Top level: right-to-left square-and-multiply modular exponentiation.
// Depends on modexp_pkg and modexp_mul (two instances: multiply and square).
`timescale 1ns / 1ps
// The exponent used is modulus - 2 for the inverse; a modulus below 2 skips the multiplies
// and gives result 0.
// Each exponent bit costs one 32-step bit-serial multiply, multiply and square running in parallel.
// One word in work at a time; a new word is taken once the previous result is in the output reg.
// Async active-low reset clears control state and loads modulus with 1000000007.

module modular_exponentiation #(
	parameter int MOD_WIDTH = 31,
	parameter int EXP_WIDTH = 63
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [MOD_WIDTH-1:0]  wr_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  op,
	input  logic [31:0]           base,
	input  logic [EXP_WIDTH-1:0]  exponent,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [MOD_WIDTH-1:0]  result
);

	// exponent register also holds modulus - 2
	localparam int E_W = (EXP_WIDTH > MOD_WIDTH) ? EXP_WIDTH : MOD_WIDTH;

	modexp_pkg::state_t state_q, state_nxt;

	logic [MOD_WIDTH-1:0] modulus_q;
	logic [E_W-1:0]       e_q;
	logic [MOD_WIDTH-1:0] acc_q;
	logic [MOD_WIDTH-1:0] b_q;
	logic [MOD_WIDTH-1:0] result_q;
	logic                 out_valid_q;

	logic                 accept;
	logic                 mod_small;
	logic                 out_free;
	logic                 start0;
	logic                 start1;
	logic                 done0;
	logic                 done1;
	logic [modexp_pkg::BASE_WIDTH-1:0] a0;
	logic [MOD_WIDTH-1:0] b0;
	logic [MOD_WIDTH-1:0] p0;
	logic [MOD_WIDTH-1:0] p1;

	assign mod_small = (modulus_q < MOD_WIDTH'(2));
	assign out_free  = !out_valid_q || !out_stall;
	assign accept    = in_valid && !in_stall;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			modexp_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nxt = mod_small ? modexp_pkg::ST_FINISH : modexp_pkg::ST_REDUCE;
				end
			end
			modexp_pkg::ST_REDUCE: begin
				if (done0) begin
					state_nxt = modexp_pkg::ST_STEP;
				end
			end
			modexp_pkg::ST_STEP: begin
				state_nxt = (e_q == '0) ? modexp_pkg::ST_FINISH : modexp_pkg::ST_MUL;
			end
			modexp_pkg::ST_MUL: begin
				if (done0) begin
					state_nxt = modexp_pkg::ST_STEP;
				end
			end
			modexp_pkg::ST_FINISH: begin
				if (out_free) begin
					state_nxt = modexp_pkg::ST_IDLE;
				end
			end
			default: state_nxt = modexp_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall = 1'b1;
		start0   = 1'b0;
		start1   = 1'b0;
		a0       = {{(modexp_pkg::BASE_WIDTH - MOD_WIDTH){1'b0}}, acc_q};
		b0       = b_q;
		case (state_q)
			modexp_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				// base mod m is computed as base * 1
				start0   = in_valid && !mod_small;
				a0       = base;
				b0       = MOD_WIDTH'(1);
			end
			modexp_pkg::ST_STEP: begin
				start0 = (e_q != '0);
				start1 = (e_q != '0);
			end
			default: begin
			end
		endcase
	end

	modexp_mul #(.W(MOD_WIDTH)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start0),
		.a      (a0),
		.b      (b0),
		.m      (modulus_q),
		.done   (done0),
		.p      (p0)
	);

	modexp_mul #(.W(MOD_WIDTH)) u_sqr (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start1),
		.a      ({{(modexp_pkg::BASE_WIDTH - MOD_WIDTH){1'b0}}, b_q}),
		.b      (b_q),
		.m      (modulus_q),
		.done   (done1),
		.p      (p1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= modexp_pkg::ST_IDLE;
			modulus_q   <= MOD_WIDTH'(modexp_pkg::MODULUS_RESET);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (wr_en) begin
				modulus_q <= wr_data;
			end
			if (state_q == modexp_pkg::ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			modexp_pkg::ST_IDLE: begin
				if (accept) begin
					e_q   <= (op == modexp_pkg::OP_INVERSE) ?
						E_W'(modulus_q - MOD_WIDTH'(2)) : E_W'(exponent);
					acc_q <= mod_small ? '0 : MOD_WIDTH'(1);
				end
			end
			modexp_pkg::ST_REDUCE: begin
				if (done0) begin
					b_q <= p0;
				end
			end
			modexp_pkg::ST_MUL: begin
				if (done0 && done1) begin
					if (e_q[0]) begin
						acc_q <= p0;
					end
					b_q <= p1;
					e_q <= e_q >> 1;
				end
			end
			modexp_pkg::ST_FINISH: begin
				if (out_free) begin
					result_q <= acc_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

endmodule

// ===== hw/rtl/modexp_mul.sv =====
// Bit-serial interleaved modular multiplier: p = a * b mod m, one bit of a per cycle.
// Depends on modexp_pkg (BASE_WIDTH, CNT_W).
`timescale 1ns / 1ps

module modexp_mul #(
	parameter int W = 31
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [modexp_pkg::BASE_WIDTH-1:0]  a,
	input  logic [W-1:0]                       b,
	input  logic [W-1:0]                       m,
	output logic                               done,
	output logic [W-1:0]                       p
);

	logic                              busy_q;
	logic                              done_q;
	logic [modexp_pkg::CNT_W-1:0]      cnt_q;
	logic [modexp_pkg::BASE_WIDTH-1:0] a_q;
	logic [W-1:0]                      b_q;
	logic [W-1:0]                      acc_q;
	logic [W-1:0]                      acc_nxt;
	logic [W+1:0]                      t;
	logic [W+1:0]                      m1;
	logic [W+1:0]                      m2;
	logic [W+1:0]                      d1;
	logic [W+1:0]                      d2;

	// acc < m and b < m, so 2*acc + b < 3m: at most one of m or 2m comes off
	always_comb begin
		t  = {1'b0, acc_q, 1'b0} + (a_q[modexp_pkg::BASE_WIDTH-1] ? {2'b00, b_q} : '0);
		m1 = {2'b00, m};
		m2 = {1'b0, m, 1'b0};
		d1 = t - m1;
		d2 = t - m2;
		if (t >= m2) begin
			acc_nxt = d2[W-1:0];
		end else if (t >= m1) begin
			acc_nxt = d1[W-1:0];
		end else begin
			acc_nxt = t[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= modexp_pkg::CNT_W'(modexp_pkg::BASE_WIDTH - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			a_q   <= {a_q[modexp_pkg::BASE_WIDTH-2:0], 1'b0};
			acc_q <= acc_nxt;
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule

// ===== hw/rtl/modexp_chk.sv =====
// Port-level checker for modular_exponentiation, attached by bind.
// Depends on modexp_pkg for the modulus reset value.
`timescale 1ns / 1ps

module modexp_chk #(
	parameter int MOD_WIDTH = 31,
	parameter int EXP_WIDTH = 63
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  wr_en,
	input logic [MOD_WIDTH-1:0]  wr_data,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  op,
	input logic [31:0]           base,
	input logic [EXP_WIDTH-1:0]  exponent,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [MOD_WIDTH-1:0]  result
);

	// shadow of the modulus register as seen on the write port
	logic [MOD_WIDTH-1:0] mod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= MOD_WIDTH'(modexp_pkg::MODULUS_RESET);
		end else if (wr_en) begin
			mod_q <= wr_data;
		end
	end

	// a result is always a residue of the current modulus
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((mod_q < MOD_WIDTH'(2)) ? (result == '0) : (result < mod_q)))
		else $error("result outside residue range");

	// one word in work at a time: an accepted word blocks the input next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while a word is in work");

	// a stalled input word stays offered and unchanged
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_stall) |=>
			(in_valid && $stable(op) && $stable(base) && $stable(exponent)))
		else $error("stalled input word changed");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(result))
		else $error("stalled output word changed");

endmodule

bind modular_exponentiation modexp_chk #(
	.MOD_WIDTH (MOD_WIDTH),
	.EXP_WIDTH (EXP_WIDTH)
) u_modexp_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.wr_en     (wr_en),
	.wr_data   (wr_data),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.op        (op),
	.base      (base),
	.exponent  (exponent),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.result    (result)
);
